// ----- hw/rtl/paged_framebuffer_rect_fill_top_macros.svh -----
// Assertion macros shared by the framebuffer RTL.
// No dependencies; each macro expects aclk and aresetn in scope.
`ifndef PAGED_FRAMEBUFFER_RECT_FILL_TOP_MACROS_SVH
`define PAGED_FRAMEBUFFER_RECT_FILL_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pfb_pkg.sv -----
// Package for the paged framebuffer: command codes, field widths and defaults.
// No dependencies.
package pfb_pkg;

    localparam int SCREEN_COLUMNS_DEF = 128;
    localparam int SCREEN_ROWS_DEF    = 32;

    localparam int CMD_W     = 2;
    localparam int COORD_W   = 9;
    localparam int SPAN_W    = 8;
    localparam int INDEX_W   = 9;
    localparam int DATA_W    = 8;
    localparam int PAGE_ROWS = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Bits lo..hi (inclusive) of a page byte set.
    function automatic logic [DATA_W-1:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] lower;
        upper = 8'hFF << lo;
        lower = 8'hFF >> (3'd7 - hi);
        return upper & lower;
    endfunction

endpackage

// ----- hw/rtl/pfb_store.sv -----
// Single-port-write, single-port-read byte memory holding the frame.
// Depends on pfb_pkg for the byte width.
module pfb_store import pfb_pkg::*; #(
    parameter int DEPTH = SCREEN_COLUMNS_DEF * (SCREEN_ROWS_DEF / PAGE_ROWS),
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/paged_framebuffer_rect_fill_top.sv -----
// Monochrome page-layout framebuffer with pixel write, rectangle fill,
// clear and byte read. Depends on pfb_pkg, pfb_store and the macros header.
//
// The frame is SCREEN_COLUMNS by SCREEN_ROWS pixels, stored as bytes of eight
// vertical pixels: bit (row mod 8) of byte (row / 8) * SCREEN_COLUMNS + column.
// Each accepted item is one command and produces exactly one result item,
// whose read_data is the addressed byte for a read and zero otherwise. Items
// are handled one at a time; s_ready is high only while the sequencer is idle,
// but a finished result waits in the output register, so the next item can be
// taken while the previous result is still unclaimed. Every store access goes
// through the single memory port pair, one byte per cycle, and that port sets
// the cost of each command. A clear writes every byte of the store, a fill
// reads and writes back each byte it touches and steps through each page it
// crosses, a pixel write does the same for its one byte, and a read fetches
// one byte; a rectangle or pixel wholly off the screen and a read index
// beyond the store touch no byte. A result that is still waiting for m_ready
// when the next one is ready holds the sequencer until the output register
// frees up. After reset the store is cleared by the same walk, and s_ready
// stays low until that walk is done.
`include "paged_framebuffer_rect_fill_top_macros.svh"

module paged_framebuffer_rect_fill_top import pfb_pkg::*; #(
    parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CMD_W-1:0]          s_cmd,
    input  logic signed [COORD_W-1:0] s_x_pos,
    input  logic signed [COORD_W-1:0] s_y_pos,
    input  logic [SPAN_W-1:0]         s_rect_width,
    input  logic [SPAN_W-1:0]         s_rect_height,
    input  logic                      s_pixel_value,
    input  logic [INDEX_W-1:0]        s_read_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DATA_W-1:0]         m_read_data
);

    // Geometry derived from the screen size.
    localparam int PAGES       = (SCREEN_ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = PAGES * SCREEN_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W       = ($clog2(SCREEN_ROWS) > 3) ? $clog2(SCREEN_ROWS) : 4;
    localparam int PAGE_W      = ROW_W - 3;
    localparam int EXT_W       = COORD_W + 1;

    localparam logic [ADDR_W-1:0]       LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic [ADDR_W-1:0]       PAGE_STEP = ADDR_W'(SCREEN_COLUMNS);
    localparam logic signed [EXT_W-1:0] COL_MAX   = EXT_W'(SCREEN_COLUMNS - 1);
    localparam logic signed [EXT_W-1:0] ROW_MAX   = EXT_W'(SCREEN_ROWS - 1);
    localparam logic signed [EXT_W-1:0] EXT_ZERO  = '0;

    // Sequencer states.
    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_CLEAR = 4'd0;
    localparam logic [STATE_W-1:0] ST_IDLE  = 4'd1;
    localparam logic [STATE_W-1:0] ST_SETUP = 4'd2;
    localparam logic [STATE_W-1:0] ST_PAGE  = 4'd3;
    localparam logic [STATE_W-1:0] ST_FILL  = 4'd4;
    localparam logic [STATE_W-1:0] ST_DRAIN = 4'd5;
    localparam logic [STATE_W-1:0] ST_READ  = 4'd6;
    localparam logic [STATE_W-1:0] ST_RDATA = 4'd7;
    localparam logic [STATE_W-1:0] ST_RESP  = 4'd8;

    // Control registers.
    logic [STATE_W-1:0] state_reg, state_next;
    logic               boot_reg, boot_next;
    logic               wr_pend_reg, wr_pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    // Item and walk registers.
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic [SPAN_W-1:0]         w_reg, w_next;
    logic [SPAN_W-1:0]         h_reg, h_next;
    logic [INDEX_W-1:0]        ridx_reg, ridx_next;
    logic                      set_reg, set_next;
    logic [COL_W-1:0]          col_lo_reg, col_lo_next;
    logic [COL_W-1:0]          col_hi_reg, col_hi_next;
    logic [ROW_W-1:0]          row_lo_reg, row_lo_next;
    logic [ROW_W-1:0]          row_hi_reg, row_hi_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [PAGE_W-1:0]         page_reg, page_next;
    logic [ADDR_W-1:0]         page_base_reg, page_base_next;
    logic [DATA_W-1:0]         mask_reg, mask_next;
    logic [ADDR_W-1:0]         wr_addr_reg, wr_addr_next;
    logic [DATA_W-1:0]         wr_mask_reg, wr_mask_next;
    logic                      wr_set_reg, wr_set_next;
    logic [DATA_W-1:0]         res_data_reg, res_data_next;
    logic [DATA_W-1:0]         m_data_reg, m_data_next;

    // Store port.
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    // Clipping of the rectangle; a pixel write is a rectangle of span zero.
    logic signed [EXT_W-1:0] x_ext, y_ext, x_end, y_end;
    logic signed [EXT_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [SPAN_W-1:0]       x_span, y_span;
    logic                    rect_empty;
    logic [PAGE_W-1:0]       page_first;

    // Per-page mask bounds.
    logic [PAGE_W-1:0] page_top, page_bot;
    logic [2:0]        bit_lo, bit_hi;

    logic out_free;
    logic read_in_range;

    always_comb begin
        x_span     = (cmd_reg == CMD_PIXEL) ? '0 : w_reg;
        y_span     = (cmd_reg == CMD_PIXEL) ? '0 : h_reg;
        x_ext      = {x_reg[COORD_W-1], x_reg};
        y_ext      = {y_reg[COORD_W-1], y_reg};
        x_end      = x_ext + $signed({2'b00, x_span});
        y_end      = y_ext + $signed({2'b00, y_span});
        x_lo       = (x_ext < EXT_ZERO) ? EXT_ZERO : x_ext;
        y_lo       = (y_ext < EXT_ZERO) ? EXT_ZERO : y_ext;
        x_hi       = (x_end > COL_MAX) ? COL_MAX : x_end;
        y_hi       = (y_end > ROW_MAX) ? ROW_MAX : y_end;
        rect_empty = (x_lo > x_hi) || (y_lo > y_hi);
        page_first = y_lo[ROW_W-1:3];
    end

    always_comb begin
        page_top = row_lo_reg[ROW_W-1:3];
        page_bot = row_hi_reg[ROW_W-1:3];
        bit_lo   = (page_reg == page_top) ? row_lo_reg[2:0] : 3'd0;
        bit_hi   = (page_reg == page_bot) ? row_hi_reg[2:0] : 3'd7;
    end

    assign out_free      = !m_valid_reg || m_ready;
    assign read_in_range = 32'(ridx_reg) < 32'(STORE_BYTES);

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        wr_pend_next   = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        addr_next      = addr_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        ridx_next      = ridx_reg;
        set_next       = set_reg;
        col_lo_next    = col_lo_reg;
        col_hi_next    = col_hi_reg;
        row_lo_next    = row_lo_reg;
        row_hi_next    = row_hi_reg;
        col_next       = col_reg;
        page_next      = page_reg;
        page_base_next = page_base_reg;
        mask_next      = mask_reg;
        wr_addr_next   = wr_addr_reg;
        wr_mask_next   = wr_mask_reg;
        wr_set_next    = wr_set_reg;
        res_data_next  = res_data_reg;
        m_data_next    = m_data_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        s_ready        = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                // One zero byte per cycle; the write itself is muxed below.
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    boot_next  = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_RESP;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next      = s_cmd;
                    x_next        = s_x_pos;
                    y_next        = s_y_pos;
                    w_next        = s_rect_width;
                    h_next        = s_rect_height;
                    ridx_next     = s_read_index;
                    set_next      = (s_cmd == CMD_PIXEL) ? s_pixel_value : 1'b1;
                    res_data_next = '0;
                    case (s_cmd)
                        CMD_CLEAR: begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ: begin
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_SETUP;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                if (rect_empty) begin
                    state_next = ST_RESP;
                end else begin
                    col_lo_next    = x_lo[COL_W-1:0];
                    col_hi_next    = x_hi[COL_W-1:0];
                    row_lo_next    = y_lo[ROW_W-1:0];
                    row_hi_next    = y_hi[ROW_W-1:0];
                    page_next      = page_first;
                    page_base_next = ADDR_W'(ADDR_W'(page_first) * PAGE_STEP);
                    state_next     = ST_PAGE;
                end
            end
            ST_PAGE: begin
                mask_next  = page_mask(bit_lo, bit_hi);
                addr_next  = page_base_reg + ADDR_W'(col_lo_reg);
                col_next   = col_lo_reg;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                // Read this byte now, merge and write it back next cycle.
                rd_en        = 1'b1;
                rd_addr      = addr_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg;
                wr_mask_next = mask_reg;
                wr_set_next  = set_reg;
                if (col_reg == col_hi_reg) begin
                    if (page_reg == page_bot) begin
                        state_next = ST_DRAIN;
                    end else begin
                        page_next      = page_reg + 1'b1;
                        page_base_next = page_base_reg + PAGE_STEP;
                        state_next     = ST_PAGE;
                    end
                end else begin
                    col_next  = col_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESP;
            end
            ST_READ: begin
                if (read_in_range) begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(ridx_reg);
                    state_next = ST_RDATA;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RDATA: begin
                res_data_next = rd_data;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store write: the clear walk, or the write-back of a merged byte.
    always_comb begin
        wr_en   = (state_reg == ST_CLEAR) || wr_pend_reg;
        wr_addr = (state_reg == ST_CLEAR) ? addr_reg : wr_addr_reg;
        if (state_reg == ST_CLEAR) begin
            wr_data = '0;
        end else if (wr_set_reg) begin
            wr_data = rd_data | wr_mask_reg;
        end else begin
            wr_data = rd_data & ~wr_mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            boot_reg    <= 1'b1;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            addr_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            boot_reg    <= boot_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
            addr_reg    <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        ridx_reg      <= ridx_next;
        set_reg       <= set_next;
        col_lo_reg    <= col_lo_next;
        col_hi_reg    <= col_hi_next;
        row_lo_reg    <= row_lo_next;
        row_hi_reg    <= row_hi_next;
        col_reg       <= col_next;
        page_reg      <= page_next;
        page_base_reg <= page_base_next;
        mask_reg      <= mask_next;
        wr_addr_reg   <= wr_addr_next;
        wr_mask_reg   <= wr_mask_next;
        wr_set_reg    <= wr_set_next;
        res_data_reg  <= res_data_next;
        m_data_reg    <= m_data_next;
    end

    pfb_store #(
        .DEPTH(STORE_BYTES)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

    // Conditions watched by the checks below.
    logic in_clear;
    logic in_fill;
    logic fill_in_bounds;
    logic fill_wb_seen;
    logic nonread_resp;
    logic zero_result;

    assign in_clear       = state_reg == ST_CLEAR;
    assign in_fill        = state_reg == ST_FILL;
    assign fill_in_bounds = (addr_reg <= LAST_ADDR) && (col_reg <= col_hi_reg)
                            && (col_reg >= col_lo_reg);
    assign fill_wb_seen   = wr_pend_reg && (state_reg != ST_CLEAR);
    assign nonread_resp   = (state_reg == ST_RESP) && out_free && (cmd_reg != CMD_READ);
    assign zero_result    = m_valid && (m_read_data == '0);

    // A clear walk never overlaps with taking a new item.
    `PFB_ASSERT_SAME(a_clear_blocks_input, in_clear, !s_ready, "input taken during clear walk")

    // The fill walk stays inside the store and inside the clipped columns.
    `PFB_ASSERT_SAME(a_fill_in_bounds, in_fill, fill_in_bounds, "fill walk left its bounds")

    // Every read issued by the fill walk is followed by its write-back.
    `PFB_ASSERT_NEXT(a_fill_writeback, in_fill, fill_wb_seen, "fill read without write-back")

    // Commands other than a read report zero.
    `PFB_ASSERT_NEXT(a_nonread_zero, nonread_resp, zero_result, "nonzero data for a non-read")

endmodule

// ----- tb/sv/tb_paged_framebuffer_rect_fill_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the paged monochrome framebuffer with rectangle fill.
// Depends on pfb_pkg and the paged_framebuffer_rect_fill_top RTL; reads no files.

module tb_paged_framebuffer_rect_fill_top import pfb_pkg::*; ();

    // Geometry of the default build, and the size of the byte store behind it.
    localparam int COLS        = SCREEN_COLUMNS_DEF;
    localparam int ROWS        = SCREEN_ROWS_DEF;
    localparam int PAGES       = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = PAGES * COLS;

    // The slowest command is a fill of the whole screen. With 750 items, sender
    // gaps and receiver stalls, a correct run stays well under this limit, so
    // it only trips on a hang.
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_ITEMS = 725;
    localparam int HOLD_OFF     = 3000;

    // One command as the sender presents it, every field at its port width.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [SPAN_W-1:0]  rect_width;
        logic [SPAN_W-1:0]  rect_height;
        logic               pixel_value;
        logic [INDEX_W-1:0] read_index;
    } draw_cmd_t;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd         = '0;
    logic [COORD_W-1:0]  s_x_pos       = '0;
    logic [COORD_W-1:0]  s_y_pos       = '0;
    logic [SPAN_W-1:0]   s_rect_width  = '0;
    logic [SPAN_W-1:0]   s_rect_height = '0;
    logic                s_pixel_value = 1'b0;
    logic [INDEX_W-1:0]  s_read_index  = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [DATA_W-1:0]   m_read_data;

    // Commands waiting to be offered, and the read_data each accepted command
    // is expected to return, oldest first.
    draw_cmd_t         queued_cmds[$];
    logic [DATA_W-1:0] expected_read_data[$];

    // The testbench's own copy of the frame, kept in the page layout.
    logic [DATA_W-1:0] frame_bytes [STORE_BYTES];

    int error_count = 0;
    int cycle_count = 0;

    // Last drawing position, so that most reads land on bytes just touched.
    int last_col = 0;
    int last_row = 0;

    paged_framebuffer_rect_fill_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_x_pos       (s_x_pos),
        .s_y_pos       (s_y_pos),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .s_pixel_value (s_pixel_value),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------

    // Pixels outside the screen are dropped here, which covers both the
    // off-screen pixel write and the clipping of rectangles.
    function automatic void paint_pixel(int col, int row, logic lit);
        int idx;
        if (col < 0 || col >= COLS || row < 0 || row >= ROWS) begin
            return;
        end
        idx = (row / PAGE_ROWS) * COLS + col;
        frame_bytes[idx][row % PAGE_ROWS] = lit;
    endfunction

    // Applies one command to the frame copy and returns the read_data that the
    // block must produce for it: the addressed byte for a read, zero otherwise.
    function automatic logic [DATA_W-1:0] apply_draw_cmd(draw_cmd_t item);
        int col0;
        int row0;
        int col1;
        int row1;
        logic [DATA_W-1:0] data;
        data = '0;
        case (item.cmd)
            CMD_CLEAR: begin
                foreach (frame_bytes[i]) begin
                    frame_bytes[i] = '0;
                end
            end
            CMD_PIXEL: begin
                col0 = $signed(item.x_pos);
                row0 = $signed(item.y_pos);
                paint_pixel(col0, row0, item.pixel_value);
            end
            CMD_FILL: begin
                col0 = $signed(item.x_pos);
                row0 = $signed(item.y_pos);
                col1 = col0 + int'(item.rect_width);
                row1 = row0 + int'(item.rect_height);
                if (col0 < 0) col0 = 0;
                if (row0 < 0) row0 = 0;
                if (col1 > COLS - 1) col1 = COLS - 1;
                if (row1 > ROWS - 1) row1 = ROWS - 1;
                for (int rr = row0; rr <= row1; rr++) begin
                    for (int cc = col0; cc <= col1; cc++) begin
                        paint_pixel(cc, rr, 1'b1);
                    end
                end
            end
            default: begin
                if (int'(item.read_index) < STORE_BYTES) begin
                    data = frame_bytes[item.read_index];
                end
            end
        endcase
        return data;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, int x, int y, int w, int h,
                             logic lit, int idx);
        draw_cmd_t item;
        item.cmd         = cmd;
        item.x_pos       = x[COORD_W-1:0];
        item.y_pos       = y[COORD_W-1:0];
        item.rect_width  = w[SPAN_W-1:0];
        item.rect_height = h[SPAN_W-1:0];
        item.pixel_value = lit;
        item.read_index  = idx[INDEX_W-1:0];
        queued_cmds.push_back(item);
    endtask

    // Mostly on-screen coordinates; now and then any 9-bit value, which takes
    // in negative positions and columns or rows far beyond the edge.
    function automatic logic [COORD_W-1:0] pick_coord(int span);
        if ($urandom_range(0, 9) < 8) begin
            return COORD_W'($urandom_range(0, span - 1));
        end
        return COORD_W'($urandom());
    endfunction

    // Random command. Fields that the command does not use stay random, so the
    // block sees noise on them. Draws are small and frequent and reads mostly
    // look at the byte just drawn, so the checks see pixels being changed.
    function automatic draw_cmd_t random_draw_cmd();
        draw_cmd_t item;
        int pick;
        int idx;
        item = draw_cmd_t'($bits(draw_cmd_t)'({$urandom(), $urandom()}));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            item.cmd = CMD_CLEAR;
        end else if (pick < 32) begin
            item.cmd   = CMD_PIXEL;
            item.x_pos = pick_coord(COLS);
            item.y_pos = pick_coord(ROWS);
            last_col   = $signed(item.x_pos);
            last_row   = $signed(item.y_pos);
        end else if (pick < 60) begin
            item.cmd   = CMD_FILL;
            item.x_pos = pick_coord(COLS);
            item.y_pos = pick_coord(ROWS);
            if ($urandom_range(0, 19) != 0) begin
                item.rect_width  = SPAN_W'($urandom_range(0, 12));
                item.rect_height = SPAN_W'($urandom_range(0, 9));
            end
            last_col = $signed(item.x_pos);
            last_row = $signed(item.y_pos);
        end else begin
            item.cmd = CMD_READ;
            if ($urandom_range(0, 9) < 6) begin
                idx = ((last_row & (ROWS - 1)) / PAGE_ROWS) * COLS + (last_col & (COLS - 1));
                idx = idx + $urandom_range(0, 3);
                item.read_index = idx[INDEX_W-1:0];
            end
        end
        return item;
    endfunction

    // Directed opening, then random commands. Everything is queued at time
    // zero; the driver takes it from there.
    initial begin
        foreach (frame_bytes[i]) begin
            frame_bytes[i] = '0;
        end

        // The store must read back clear after reset.
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 0);
        // Corner pixels, with a read of the last store byte.
        queue_cmd(CMD_PIXEL, 0,    0,    0,   0,   1'b1, 0);
        queue_cmd(CMD_PIXEL, 127,  31,   0,   0,   1'b1, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, STORE_BYTES - 1);
        // Pixel writes just past the left, right and bottom edges and at the
        // coordinate extremes must leave the frame alone.
        queue_cmd(CMD_PIXEL, -1,   0,    0,   0,   1'b1, 0);
        queue_cmd(CMD_PIXEL, 128,  5,    0,   0,   1'b1, 0);
        queue_cmd(CMD_PIXEL, 0,    32,   0,   0,   1'b1, 0);
        queue_cmd(CMD_PIXEL, -256, -256, 0,   0,   1'b1, 0);
        queue_cmd(CMD_PIXEL, 255,  255,  0,   0,   1'b1, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 0);
        // Darken a lit pixel.
        queue_cmd(CMD_PIXEL, 0,    0,    0,   0,   1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 0);
        // Rectangle hanging off the top-left corner.
        queue_cmd(CMD_FILL,  -3,   -3,   5,   10,  1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 2);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 3);
        // Rectangle wholly off the screen, at the most negative origin.
        queue_cmd(CMD_FILL,  -256, -256, 255, 255, 1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 384);
        // Rectangle hanging off the bottom-right corner.
        queue_cmd(CMD_FILL,  120,  28,   255, 255, 1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, STORE_BYTES - 1);
        // Whole screen lit, then cleared.
        queue_cmd(CMD_FILL,  0,    0,    255, 255, 1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 300);
        queue_cmd(CMD_CLEAR, 0,    0,    0,   0,   1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, STORE_BYTES - 1);
        // A ball: a square fill that straddles a page boundary.
        queue_cmd(CMD_FILL,  10,   5,    4,   4,   1'b0, 0);
        queue_cmd(CMD_READ,  0,    0,    0,   0,   1'b0, 138);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queued_cmds.push_back(random_draw_cmd());
        end
    end

    // Reset is held at the start and never again.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // The sender works in bursts. An item stays on the port, unchanged, until
    // it is taken; only then may the next one follow or a gap begin. The
    // expectation for an item is computed at the edge where it is accepted.
    draw_cmd_t offered_cmd;
    int        burst_left = 1;
    int        gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_read_data.push_back(apply_draw_cmd(offered_cmd));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_cmds.size() != 0) begin
                    offered_cmd    = queued_cmds.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= offered_cmd.cmd;
                    s_x_pos       <= offered_cmd.x_pos;
                    s_y_pos       <= offered_cmd.y_pos;
                    s_rect_width  <= offered_cmd.rect_width;
                    s_rect_height <= offered_cmd.rect_height;
                    s_pixel_value <= offered_cmd.pixel_value;
                    s_read_index  <= offered_cmd.read_index;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(1, 30);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // The receiver switches among stall patterns: always ready, a coin toss,
    // mostly stalled, or a fixed duty cycle. Once, after a couple of hundred
    // items have gone in, it holds off for a long stretch so that the output
    // register fills and the block stops taking items.
    int stall_mode   = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int taken_so_far = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken_so_far++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && taken_so_far >= 200) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF;
                m_ready  <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 300);
                end
                mode_left--;
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1) == 1;
                    2:       m_ready <= $urandom_range(0, 3) == 0;
                    default: m_ready <= (cycle_count % 7) < 2;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------

    // Every result taken is matched against the oldest expectation.
    always @(posedge aclk) begin
        logic [DATA_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_read_data.size() == 0) begin
                $error("read_data: no result expected, actual %02h", m_read_data);
                error_count++;
            end else begin
                want = expected_read_data.pop_front();
                if (m_read_data !== want) begin
                    $error("read_data: expected %02h, actual %02h", want, m_read_data);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // End of run: all items taken and all results in, then a quiet stretch
    // long enough for the slowest command, in case a stray result shows up.
    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        while (queued_cmds.size() != 0 || s_valid || expected_read_data.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
